@@ design/gpm_pkg.sv @@
package gpm_pkg;

   localparam int PINS_PER_PORT = 8;
   localparam int PORT_COUNT = 2;
   localparam int PIN_TOTAL = PINS_PER_PORT * PORT_COUNT;
   localparam int PIN_IDX_W = $clog2(PIN_TOTAL);

   // Pins that can carry the timer output: 1.2, 1.6, 2.1 and 2.2.
   localparam logic [PIN_TOTAL-1:0] PWM_CAPABLE = 16'h0644;

   typedef enum logic [2:0] {
      ACT_SETUP   = 3'd0,
      ACT_RESERVE = 3'd1,
      ACT_SET     = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_TOGGLE  = 3'd4,
      ACT_READ    = 3'd5,
      ACT_EDGE    = 3'd6,
      ACT_QUERY   = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      FN_FLOAT    = 3'd0,
      FN_PULLUP   = 3'd1,
      FN_PULLDOWN = 3'd2,
      FN_OUT      = 3'd3,
      FN_ANALOG   = 3'd4,
      FN_PWM      = 3'd5,
      FN_RESERVED = 3'd6,
      FN_UNKNOWN  = 3'd7
   } fn_type;

   localparam logic [2:0] EDGE_OFF  = 3'd0;
   localparam logic [2:0] EDGE_FALL = 3'd1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADPORT = 2'd1,
      ST_UNSUP   = 2'd2
   } status_type;

   typedef enum logic {
      SM_EMPTY = 1'b0,
      SM_FULL  = 1'b1
   } sm_state_type;

   typedef struct packed {
      logic step;
   } cmd_type;

endpackage

@@ design/gpm_ctrl.sv @@
module gpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output gpm_pkg::cmd_type  cmd
);

   gpm_pkg::sm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpm_pkg::SM_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gpm_pkg::SM_EMPTY: begin
            if (req_tvalid) state_in = gpm_pkg::SM_FULL;
         end
         gpm_pkg::SM_FULL: begin
            if (rsp_tready && !req_tvalid) state_in = gpm_pkg::SM_EMPTY;
         end
         default: state_in = gpm_pkg::SM_EMPTY;
      endcase
   end

   // A new beat is taken while the held result leaves in the same cycle.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         gpm_pkg::SM_EMPTY: begin
            req_tready = 1'b1;
         end
         gpm_pkg::SM_FULL: begin
            req_tready = rsp_tready;
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
      cmd.step = req_tvalid && req_tready;
   end

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_tvalid)
      else $error("result not presented after a step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !cmd.step)
      else $error("step while a result is stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !cmd.step |=> !rsp_tvalid)
      else $error("result repeated after it was taken");

endmodule

@@ design/gpm_datapath.sv @@
module gpm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  gpm_pkg::cmd_type        cmd,
   input  logic [2:0]              action,
   input  logic [7:0]              pin,
   input  logic [2:0]              function_code,
   input  logic [15:0]             pad_levels,
   output logic [1:0]              status,
   output logic                    read_level,
   output logic [2:0]              current_function,
   output logic [15:0]             direction_bits,
   output logic [15:0]             output_bits,
   output logic [15:0]             pull_enable_bits,
   output logic [15:0]             alt_select_bits,
   output logic [15:0]             edge_select_bits,
   output logic [15:0]             irq_enable_bits
);

   localparam int N = gpm_pkg::PIN_TOTAL;
   localparam int IW = gpm_pkg::PIN_IDX_W;
   localparam int PP = gpm_pkg::PINS_PER_PORT;

   gpm_pkg::fn_type     fn_table_ff [N];
   logic [N-1:0]        dir_ff, dir_in;
   logic [N-1:0]        out_ff, out_in;
   logic [N-1:0]        pull_ff, pull_in;
   logic [N-1:0]        alt_ff, alt_in;
   logic [N-1:0]        edge_ff, edge_in;
   logic [N-1:0]        irq_ff, irq_in;
   gpm_pkg::status_type status_ff, status_in;
   logic                level_ff, level_in;
   gpm_pkg::fn_type     cf_ff, cf_in;

   gpm_pkg::action_type act;
   gpm_pkg::fn_type     fn;
   gpm_pkg::fn_type     cur;
   gpm_pkg::fn_type     new_fn;
   logic [3:0]          port_nib;
   logic [3:0]          bit_nib;
   logic                pin_ok;
   logic [IW-1:0]       idx;
   logic [N-1:0]        m;
   logic [N-1:0]        pwm_vec;
   logic [N-1:0]        port_sel;
   logic                fn_wr;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         pwm_vec[i] = (fn_table_ff[i] == gpm_pkg::FN_PWM);
      end
   end

   assign act      = gpm_pkg::action_type'(action);
   assign fn       = gpm_pkg::fn_type'(function_code);
   assign port_nib = pin[7:4];
   assign bit_nib  = pin[3:0];
   assign pin_ok   = (port_nib == 4'd1 || port_nib == 4'd2) && (bit_nib < 4'(PP));
   assign idx      = {port_nib == 4'd2, bit_nib[IW-2:0]};
   assign m        = pin_ok ? (N'(1) << idx) : '0;
   assign cur      = pin_ok ? fn_table_ff[idx] : gpm_pkg::FN_UNKNOWN;
   assign port_sel = idx[IW-1] ? {{PP{1'b1}}, {PP{1'b0}}} : {{PP{1'b0}}, {PP{1'b1}}};

   always_comb begin
      dir_in    = dir_ff;
      out_in    = out_ff;
      pull_in   = pull_ff;
      alt_in    = alt_ff;
      edge_in   = edge_ff;
      irq_in    = irq_ff;
      status_in = gpm_pkg::ST_OK;
      level_in  = 1'b0;
      new_fn    = cur;
      fn_wr     = 1'b0;
      unique case (act)
         gpm_pkg::ACT_SETUP: begin
            if (!pin_ok) begin
               status_in = gpm_pkg::ST_BADPORT;
            end else if (cur == fn) begin
               status_in = gpm_pkg::ST_OK;
            end else if (cur == gpm_pkg::FN_RESERVED) begin
               status_in = gpm_pkg::ST_UNSUP;
            end else begin
               case (fn)
                  gpm_pkg::FN_FLOAT: begin
                     dir_in = dir_ff & ~m; pull_in = pull_ff & ~m; alt_in = alt_ff & ~m;
                     fn_wr = 1'b1;
                  end
                  gpm_pkg::FN_PULLUP: begin
                     dir_in = dir_ff & ~m; out_in = out_ff | m;
                     pull_in = pull_ff | m; alt_in = alt_ff & ~m;
                     fn_wr = 1'b1;
                  end
                  gpm_pkg::FN_PULLDOWN: begin
                     dir_in = dir_ff & ~m; out_in = out_ff & ~m;
                     pull_in = pull_ff | m; alt_in = alt_ff & ~m;
                     fn_wr = 1'b1;
                  end
                  gpm_pkg::FN_OUT: begin
                     dir_in = dir_ff | m; out_in = out_ff & ~m;
                     pull_in = pull_ff & ~m; alt_in = alt_ff & ~m;
                     fn_wr = 1'b1;
                  end
                  gpm_pkg::FN_ANALOG: begin
                     if (idx[IW-1]) begin
                        status_in = gpm_pkg::ST_UNSUP;
                     end else begin
                        dir_in = dir_ff & ~m; pull_in = pull_ff & ~m; alt_in = alt_ff & ~m;
                        fn_wr = 1'b1;
                     end
                  end
                  gpm_pkg::FN_PWM: begin
                     // The addressed pin is not PWM here, so any PWM pin in the
                     // port is another one.
                     if (!gpm_pkg::PWM_CAPABLE[idx] || |(pwm_vec & port_sel)) begin
                        status_in = gpm_pkg::ST_UNSUP;
                     end else begin
                        dir_in = dir_ff | m; out_in = out_ff & ~m;
                        pull_in = pull_ff & ~m; alt_in = alt_ff | m;
                        fn_wr = 1'b1;
                     end
                  end
                  default: status_in = gpm_pkg::ST_UNSUP;
               endcase
               if (fn_wr) new_fn = fn;
            end
         end
         gpm_pkg::ACT_RESERVE: begin
            if (pin_ok) begin
               new_fn = gpm_pkg::FN_RESERVED;
               fn_wr = 1'b1;
            end else begin
               status_in = gpm_pkg::ST_BADPORT;
            end
         end
         gpm_pkg::ACT_SET, gpm_pkg::ACT_CLEAR, gpm_pkg::ACT_TOGGLE: begin
            if (cur != gpm_pkg::FN_OUT) begin
               status_in = gpm_pkg::ST_UNSUP;
            end else if (act == gpm_pkg::ACT_SET) begin
               out_in = out_ff | m;
            end else if (act == gpm_pkg::ACT_CLEAR) begin
               out_in = out_ff & ~m;
            end else begin
               out_in = out_ff ^ m;
            end
         end
         gpm_pkg::ACT_READ: begin
            if (cur == gpm_pkg::FN_ANALOG || cur == gpm_pkg::FN_RESERVED ||
                cur == gpm_pkg::FN_UNKNOWN) begin
               status_in = gpm_pkg::ST_UNSUP;
            end else begin
               level_in = |(pad_levels & m);
            end
         end
         gpm_pkg::ACT_EDGE: begin
            if (cur != gpm_pkg::FN_FLOAT && cur != gpm_pkg::FN_PULLUP &&
                cur != gpm_pkg::FN_PULLDOWN) begin
               status_in = gpm_pkg::ST_UNSUP;
            end else begin
               edge_in = (function_code == gpm_pkg::EDGE_FALL) ? (edge_ff | m) : (edge_ff & ~m);
               irq_in  = (function_code == gpm_pkg::EDGE_OFF) ? (irq_ff & ~m) : (irq_ff | m);
            end
         end
         gpm_pkg::ACT_QUERY: begin
            if (!pin_ok) status_in = gpm_pkg::ST_BADPORT;
         end
         default: status_in = gpm_pkg::ST_UNSUP;
      endcase
      cf_in = pin_ok ? new_fn : gpm_pkg::FN_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            fn_table_ff[i] <= gpm_pkg::FN_FLOAT;
         end
         dir_ff  <= '0;
         out_ff  <= '0;
         pull_ff <= '0;
         alt_ff  <= '0;
         edge_ff <= '0;
         irq_ff  <= '0;
      end else if (cmd.step) begin
         if (fn_wr) fn_table_ff[idx] <= new_fn;
         dir_ff  <= dir_in;
         out_ff  <= out_in;
         pull_ff <= pull_in;
         alt_ff  <= alt_in;
         edge_ff <= edge_in;
         irq_ff  <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         status_ff <= status_in;
         level_ff  <= level_in;
         cf_ff     <= cf_in;
      end
   end

   assign status           = status_ff;
   assign read_level       = level_ff;
   assign current_function = cf_ff;
   assign direction_bits   = dir_ff;
   assign output_bits      = out_ff;
   assign pull_enable_bits = pull_ff;
   assign alt_select_bits  = alt_ff;
   assign edge_select_bits = edge_ff;
   assign irq_enable_bits  = irq_ff;

   a_one_pwm_per_port: assert property (@(posedge clock) disable iff (reset)
      $countones(pwm_vec[PP-1:0]) <= 1 && $countones(pwm_vec[N-1:PP]) <= 1)
      else $error("more than one PWM pin in a port");

   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status_in != gpm_pkg::ST_OK |=>
         $stable(dir_ff) && $stable(out_ff) && $stable(pull_ff) && $stable(alt_ff) &&
         $stable(edge_ff) && $stable(irq_ff))
      else $error("failed step changed pin registers");

   a_bad_pin_unknown: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !pin_ok |=> cf_ff == gpm_pkg::FN_UNKNOWN && status_ff != gpm_pkg::ST_OK)
      else $error("invalid pin reported a real function");

endmodule

@@ design/gpio_pin_function_manager.sv @@
// GPIO function manager for two eight-pin ports. Each request beat carries one
// action on one pin; the block answers with exactly one response beat holding
// the status, the read level, the pin's function and all six per-pin register
// images after the action. Every action is decided and committed in the cycle
// its beat is accepted, and the response is held in an output register, so a
// beat is answered in the next cycle and a new beat can be taken every
// cycle as long as the response side keeps taking beats. This rate rests on
// updating the sixteen-entry function table and the pin registers together
// on acceptance. Reset puts all pins in input-float mode with all bits cleared.
module gpio_pin_function_manager (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[2:0], pin[10:3], function_code[13:11], pad_levels[29:14], zero[31:30]
   input  logic [31:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], read_level[2], current_function[5:3], direction_bits[21:6],
   // output_bits[37:22], pull_enable_bits[53:38], alt_select_bits[69:54],
   // edge_select_bits[85:70], irq_enable_bits[101:86], zero[103:102]
   output logic [103:0] rsp_tdata
);

   gpm_pkg::cmd_type cmd;

   logic [1:0]  status;
   logic        read_level;
   logic [2:0]  current_function;
   logic [15:0] direction_bits;
   logic [15:0] output_bits;
   logic [15:0] pull_enable_bits;
   logic [15:0] alt_select_bits;
   logic [15:0] edge_select_bits;
   logic [15:0] irq_enable_bits;

   gpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   gpm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .action           (req_tdata[2:0]),
      .pin              (req_tdata[10:3]),
      .function_code    (req_tdata[13:11]),
      .pad_levels       (req_tdata[29:14]),
      .status           (status),
      .read_level       (read_level),
      .current_function (current_function),
      .direction_bits   (direction_bits),
      .output_bits      (output_bits),
      .pull_enable_bits (pull_enable_bits),
      .alt_select_bits  (alt_select_bits),
      .edge_select_bits (edge_select_bits),
      .irq_enable_bits  (irq_enable_bits)
   );

   assign rsp_tdata = {2'b00, irq_enable_bits, edge_select_bits, alt_select_bits,
                       pull_enable_bits, output_bits, direction_bits,
                       current_function, read_level, status};

endmodule
